// ===== rtl/lfdx_pkg.sv =====
// shared constants and types for the lidar frame deframer
package lfdx_pkg;

  localparam int FRAME_LENGTH = 64;
  localparam int ADDR_W       = $clog2(FRAME_LENGTH);
  localparam int BYTE_W       = 8;
  localparam int NIB_W        = 4;
  localparam int IDX_W        = 6;
  localparam int CFG_IDX_W    = 2;

  typedef logic [ADDR_W-1:0]    addr_t;
  typedef logic [BYTE_W-1:0]    byte_t;
  typedef logic [NIB_W-1:0]     nib_t;
  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam addr_t POS_HDR0   = addr_t'(0);
  localparam addr_t POS_HDR1   = addr_t'(1);
  localparam addr_t POS_XSTART = addr_t'(2);
  localparam addr_t LAST_POS   = addr_t'(FRAME_LENGTH - 1);

  localparam cfg_idx_t REG_FIRST_HDR  = cfg_idx_t'(0);
  localparam cfg_idx_t REG_SECOND_HDR = cfg_idx_t'(1);

  typedef enum logic [2:0] {
    ST_COLLECT = 3'b001,
    ST_READ    = 3'b010,
    ST_LOAD    = 3'b100
  } state_t;

  typedef struct packed {
    logic  we;
    addr_t waddr;
    byte_t wdata;
    logic  re;
    addr_t raddr;
  } ram_req_t;

endpackage

// ===== rtl/lfdx_frame_ram.sv =====
// frame store: one write port, one registered read port
module lfdx_frame_ram (
  input  logic              clk,
  input  lfdx_pkg::ram_req_t req,
  output lfdx_pkg::byte_t   rdata
);

  lfdx_pkg::byte_t mem [lfdx_pkg::FRAME_LENGTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

// ===== rtl/lidar_frame_deframer_xor_check_core.sv =====
// top level of the lidar frame deframer with xor check
//
// Bytes from the serial link are taken one per cycle while a frame is being
// collected and the output register is free: the parser hunts for the first
// header nibble, checks the second, then writes every byte of the frame into
// the frame store and keeps a running xor from byte two on. At the last byte
// the xor is compared with the low nibbles of the two header bytes. A mismatch
// gives one error item (status 1, last 1) in the cycle after the last byte. A
// match starts a walk that emits FRAME_LENGTH items, each read from the frame
// store in ST_READ and loaded into the output register in ST_LOAD once it is
// free; no byte is accepted during the walk. The user must write the header
// registers through the cfg port only while idle; nothing here enforces it.
module lidar_frame_deframer_xor_check_core (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  lfdx_pkg::cfg_idx_t       cfg_index,
  input  lfdx_pkg::nib_t           cfg_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [7:0]               rx_byte,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [7:0]               frame_byte,
  output logic [5:0]               byte_index,
  output logic                     status,
  output logic                     last
);

  lfdx_pkg::state_t   state;
  lfdx_pkg::nib_t     first_hdr;
  lfdx_pkg::nib_t     second_hdr;
  lfdx_pkg::addr_t    pos;
  lfdx_pkg::byte_t    running_xor;
  lfdx_pkg::byte_t    xor_next;
  lfdx_pkg::nib_t     hdr0_lo;
  lfdx_pkg::nib_t     hdr1_lo;
  lfdx_pkg::addr_t    rd_idx;
  lfdx_pkg::ram_req_t ram_req;
  lfdx_pkg::byte_t    ram_rdata;
  logic               in_acc;
  logic               out_free;
  logic               hdr0_hit;
  logic               hdr1_hit;
  logic               store_byte;
  logic               frame_end;
  logic               sum_bad;
  logic               out_load;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == lfdx_pkg::ST_COLLECT) && out_free;
  assign in_acc   = in_valid && in_ready;

  assign hdr0_hit = rx_byte[7:4] == first_hdr;
  assign hdr1_hit = rx_byte[7:4] == second_hdr;
  assign xor_next = running_xor ^ rx_byte;

  // output register is loaded on an error item or a walk step
  assign frame_end = in_acc && (pos == lfdx_pkg::LAST_POS);
  assign sum_bad   = xor_next != {hdr1_lo, hdr0_lo};
  assign out_load  = (frame_end && sum_bad) ||
                     ((state == lfdx_pkg::ST_LOAD) && out_free);

  always_comb begin
    store_byte = 1'b1;
    if (pos == lfdx_pkg::POS_HDR0) begin
      store_byte = hdr0_hit;
    end else if (pos == lfdx_pkg::POS_HDR1) begin
      store_byte = hdr1_hit;
    end
  end

  assign ram_req.we    = in_acc && store_byte;
  assign ram_req.waddr = pos;
  assign ram_req.wdata = rx_byte;
  assign ram_req.re    = state == lfdx_pkg::ST_READ;
  assign ram_req.raddr = rd_idx;

  lfdx_frame_ram u_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (ram_rdata)
  );

  // header registers
  always_ff @(posedge clk) begin
    if (rst) begin
      first_hdr  <= '0;
      second_hdr <= '0;
    end else if (cfg_we) begin
      if (cfg_index == lfdx_pkg::REG_FIRST_HDR) begin
        first_hdr <= cfg_data;
      end else if (cfg_index == lfdx_pkg::REG_SECOND_HDR) begin
        second_hdr <= cfg_data;
      end
    end
  end

  // parser, emission walk and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= lfdx_pkg::ST_COLLECT;
      pos         <= lfdx_pkg::POS_HDR0;
      running_xor <= '0;
      rd_idx      <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (out_valid && out_ready && !out_load) begin
        out_valid <= 1'b0;
      end
      case (state)
        lfdx_pkg::ST_COLLECT: begin
          if (in_acc) begin
            if (pos == lfdx_pkg::POS_HDR0) begin
              if (hdr0_hit) begin
                hdr0_lo <= rx_byte[3:0];
                pos     <= lfdx_pkg::POS_HDR1;
              end
            end else if (pos == lfdx_pkg::POS_HDR1) begin
              if (hdr1_hit) begin
                hdr1_lo <= rx_byte[3:0];
                pos     <= lfdx_pkg::POS_XSTART;
              end else begin
                pos <= lfdx_pkg::POS_HDR0;
              end
            end else if (pos == lfdx_pkg::POS_XSTART) begin
              running_xor <= rx_byte;
              pos         <= pos + 1'b1;
            end else begin
              running_xor <= xor_next;
              if (pos != lfdx_pkg::LAST_POS) begin
                pos <= pos + 1'b1;
              end else begin
                pos <= lfdx_pkg::POS_HDR0;
                if (sum_bad) begin
                  out_valid  <= 1'b1;
                  frame_byte <= '0;
                  byte_index <= '0;
                  status     <= 1'b1;
                  last       <= 1'b1;
                end else begin
                  rd_idx <= '0;
                  state  <= lfdx_pkg::ST_READ;
                end
              end
            end
          end
        end
        lfdx_pkg::ST_READ: begin
          state <= lfdx_pkg::ST_LOAD;
        end
        lfdx_pkg::ST_LOAD: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            frame_byte <= ram_rdata;
            byte_index <= lfdx_pkg::idx_t'(rd_idx);
            status     <= 1'b0;
            last       <= rd_idx == lfdx_pkg::LAST_POS;
            if (rd_idx == lfdx_pkg::LAST_POS) begin
              state <= lfdx_pkg::ST_COLLECT;
            end else begin
              rd_idx <= rd_idx + 1'b1;
              state  <= lfdx_pkg::ST_READ;
            end
          end
        end
        default: begin
          state <= lfdx_pkg::ST_COLLECT;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_read_then_load: assert property (@(posedge clk) disable iff (rst)
    state == lfdx_pkg::ST_READ |=> state == lfdx_pkg::ST_LOAD)
    else $error("frame store read not followed by load");

  a_err_item: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> last && frame_byte == '0 && byte_index == '0)
    else $error("malformed error item");

  a_good_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !status && last |->
      byte_index == lfdx_pkg::idx_t'(lfdx_pkg::LAST_POS))
    else $error("last marker on wrong frame byte");

  a_no_write_in_walk: assert property (@(posedge clk) disable iff (rst)
    ram_req.we |-> state == lfdx_pkg::ST_COLLECT && !ram_req.re)
    else $error("frame store written during emission");
`endif

endmodule
